// ===== design/hfpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haptic force drive package
// Shared types and constants of the haptic force to PWM drive block.
// ----------------------------------------------------------------------------
package hfpd_pkg;

	localparam int WORD_W   = 16;
	localparam int DEPTH_W  = 5;
	localparam int BYTES_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int LEVEL_W  = 6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DRIVER_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_N    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET = 2'd2;

	// Driver modes; code 3 is unused and acts like no actuator.
	localparam logic [1:0] MODE_NONE    = 2'd0;
	localparam logic [1:0] MODE_LEVEL   = 2'd1;
	localparam logic [1:0] MODE_DIVIDER = 2'd2;

	localparam logic [1:0] MODE_RESET   = MODE_LEVEL;
	localparam logic [7:0] DIVIDER_RESET = 8'd214;
	localparam logic [1:0] OFFSET_RESET = 2'd3;

	// Accepted sample formats.
	localparam logic [DEPTH_W-1:0] DEPTH_8  = 5'd8;
	localparam logic [DEPTH_W-1:0] DEPTH_16 = 5'd16;
	localparam logic [BYTES_W-1:0] BYTES_8  = 4'd1;
	localparam logic [BYTES_W-1:0] BYTES_16 = 4'd2;

	// Marker loaded into the last force when the amp switches on.
	localparam logic signed [8:0] FORCE_REARM = 9'sd128;

	typedef struct packed {
		logic               status;
		logic               amp_enabled;
		logic               drive_power_on;
		logic               pwm_root_enable;
		logic [7:0]         duty_code;
		logic               duty_write;
		logic [LEVEL_W-1:0] pmic_level;
		logic               pmic_on;
		logic               pmic_write;
	} result_t;

endpackage

// ===== design/hfpd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haptic force drive channels
// Valid/ready channels for force samples, drive results and register writes.
// ----------------------------------------------------------------------------
interface hfpd_in_if;
	logic                         valid;
	logic                         ready;
	logic [hfpd_pkg::WORD_W-1:0]  sample_word;
	logic [hfpd_pkg::DEPTH_W-1:0] bit_depth;
	logic [hfpd_pkg::BYTES_W-1:0] byte_count;

	modport source (output valid, sample_word, bit_depth, byte_count, input ready);
	modport sink   (input valid, sample_word, bit_depth, byte_count, output ready);
endinterface

interface hfpd_out_if;
	logic                         valid;
	logic                         ready;
	logic                         status;
	logic                         amp_enabled;
	logic                         drive_power_on;
	logic                         pwm_root_enable;
	logic [7:0]                   duty_code;
	logic                         duty_write;
	logic [hfpd_pkg::LEVEL_W-1:0] pmic_level;
	logic                         pmic_on;
	logic                         pmic_write;

	modport source (output valid, status, amp_enabled, drive_power_on, pwm_root_enable,
		duty_code, duty_write, pmic_level, pmic_on, pmic_write, input ready);
	modport sink   (input valid, status, amp_enabled, drive_power_on, pwm_root_enable,
		duty_code, duty_write, pmic_level, pmic_on, pmic_write, output ready);
endinterface

interface hfpd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [hfpd_pkg::CFG_IDX_W-1:0]  index;
	logic [hfpd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/haptic_force_to_pwm_drive_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haptic force to PWM drive
// Turns signed force samples into duty code and regulator level writes.
// ----------------------------------------------------------------------------
// Usage:
//   sample : force words in (sample_word, bit_depth, byte_count).
//   drive  : one result word out per sample: status, amp state and the
//            divider duty or regulator writes caused by that sample.
//   cfg    : register writes (driver_mode, divider_n, level_offset); always
//            ready, and meant to be used only while no sample is in flight.
//   Each sample is decoded, checked and applied to the amp state in the
//   cycle it is accepted; its result word goes to the output register or,
//   while drive stalls, to skid. A new sample is taken every cycle while
//   skid is empty. A 9x8 multiply and three adds on the duty path set the cycle.
//   A two-word output buffer (output register plus skid register) lets a
//   sample be taken while a result waits; sample.ready drops only when
//   both are full, so a stalled receiver loses nothing.
//   Reset clears the amp, clock and last force state, empties the buffer
//   and loads the registers with mode 1, divider 214 and offset 3.
// ----------------------------------------------------------------------------
module haptic_force_to_pwm_drive_top (
	input  logic       clk,
	input  logic       arst_n,
	hfpd_in_if.sink    sample,
	hfpd_out_if.source drive,
	hfpd_cfg_if.sink   cfg
);
	import hfpd_pkg::*;

	logic [1:0]        mode_q;
	logic [7:0]        divider_q;
	logic [1:0]        offset_q;
	logic              amp_on_q;
	logic              clock_running_q;
	logic signed [8:0] last_force_q;

	result_t out_q, skid_q, res;
	logic    out_valid_q, skid_valid_q;
	logic    push, pop;

	logic                     fmt_ok;
	logic [7:0]               raw;
	logic signed [7:0]        force_v;
	logic signed [8:0]        force_ext;
	logic signed [8:0]        nm1;
	logic signed [16:0]       prod;
	logic signed [8:0]        quot;
	logic [7:0]               duty_sum;
	logic [7:0]               duty_val;
	logic [11:0]              lvl_prod;
	logic [LEVEL_W-1:0]       lvl_val;
	logic                     amp_nxt;
	logic                     clk_nxt;
	logic signed [8:0]        last_nxt;
	logic                     is_div;
	logic                     is_lvl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RESET;
			divider_q <= DIVIDER_RESET;
			offset_q  <= OFFSET_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DRIVER_MODE:  mode_q    <= cfg.data[1:0];
				REG_DIVIDER_N:    divider_q <= cfg.data;
				REG_LEVEL_OFFSET: offset_q  <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	// Format check and force extraction.
	always_comb begin
		fmt_ok = 1'b1;
		raw    = 8'd0;
		if (sample.bit_depth == DEPTH_8 && sample.byte_count == BYTES_8) begin
			raw = sample.sample_word[7:0];
		end else if (sample.bit_depth == DEPTH_16 && sample.byte_count == BYTES_16) begin
			raw = sample.sample_word[15:8];
		end else begin
			fmt_ok = 1'b0;
		end
	end

	assign force_v   = $signed(raw);
	assign force_ext = {force_v[7], force_v};
	assign is_div    = (mode_q == MODE_DIVIDER);
	assign is_lvl    = (mode_q == MODE_LEVEL);

	// Duty: (N>>1) + (N-1)*force/256 with truncation toward zero, doubled and inverted.
	assign nm1  = $signed({1'b0, divider_q}) - 9'sd1;
	assign prod = nm1 * force_ext;
	assign quot = prod[16:8] + ((prod[16] && (prod[7:0] != 8'd0)) ? 9'sd1 : 9'sd0);
	assign duty_sum = {1'b0, divider_q[7:1]} + quot[7:0];
	assign duty_val = ~{duty_sum[6:0], 1'b0};

	// Level for a positive force: force*31/128 + offset.
	assign lvl_prod = {5'd0, force_v[6:0]} * 12'd31;
	assign lvl_val  = {1'b0, lvl_prod[11:7]} + {4'd0, offset_q};

	always_comb begin
		res                = '0;
		res.status         = ~fmt_ok;
		amp_nxt            = amp_on_q;
		clk_nxt            = clock_running_q;
		last_nxt           = last_force_q;
		if (fmt_ok && force_ext != last_force_q) begin
			last_nxt = force_ext;
			if (force_v <= 8'sd0) begin
				if (is_div && force_v < 8'sd0) begin
					res.duty_code       = duty_val;
					res.pwm_root_enable = 1'b1;
					res.duty_write      = 1'b1;
				end else if (amp_on_q) begin
					if (is_div) begin
						clk_nxt = 1'b0;
					end else if (is_lvl) begin
						res.pmic_write = 1'b1;
					end
					amp_nxt  = 1'b0;
					last_nxt = 9'sd0;
				end
			end else begin
				if (!amp_on_q) begin
					if (is_div) begin
						clk_nxt = 1'b1;
					end
					amp_nxt  = 1'b1;
					last_nxt = FORCE_REARM;
				end
				if (is_div) begin
					res.duty_code       = duty_val;
					res.pwm_root_enable = 1'b1;
					res.duty_write      = 1'b1;
				end else if (is_lvl) begin
					res.pmic_level = lvl_val;
					res.pmic_on    = 1'b1;
					res.pmic_write = 1'b1;
				end
			end
		end
		res.amp_enabled    = amp_nxt;
		res.drive_power_on = clk_nxt;
	end

	assign sample.ready = ~skid_valid_q;
	assign push = sample.valid & ~skid_valid_q;
	assign pop  = out_valid_q & drive.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_on_q        <= 1'b0;
			clock_running_q <= 1'b0;
			last_force_q    <= 9'sd0;
		end else if (push) begin
			amp_on_q        <= amp_nxt;
			clock_running_q <= clk_nxt;
			last_force_q    <= last_nxt;
		end
	end

	// Two-word output buffer: the skid register only fills while the output stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || pop) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= push;
				end else begin
					out_valid_q  <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign drive.valid           = out_valid_q;
	assign drive.status          = out_q.status;
	assign drive.amp_enabled     = out_q.amp_enabled;
	assign drive.drive_power_on  = out_q.drive_power_on;
	assign drive.pwm_root_enable = out_q.pwm_root_enable;
	assign drive.duty_code       = out_q.duty_code;
	assign drive.duty_write      = out_q.duty_write;
	assign drive.pmic_level      = out_q.pmic_level;
	assign drive.pmic_on         = out_q.pmic_on;
	assign drive.pmic_write      = out_q.pmic_write;

endmodule
